// File: rtl/nfba_pkg.sv
package nfba_pkg;

   localparam int MAP_UNITS  = 1024;
   localparam int UNIT_BYTES = 64;
   localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
   localparam int UNIT_W     = $clog2(MAP_UNITS);
   localparam int CNT_W      = UNIT_W + 1;
   localparam int LEN_W      = 17;
   localparam int OFF_W      = 16;
   localparam int WORD_BITS  = 16;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = MAP_UNITS / WORD_BITS;
   localparam int WADDR_W    = $clog2(MAP_WORDS);
   localparam int SCAN_W     = WADDR_W + 1;
   localparam int LOCAL_W    = WORD_SHIFT + 1;
   localparam int RUN_W      = CNT_W + 1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_init;
      logic scan_step;
      logic upd_init;
      logic upd_step;
      logic respond;
      logic success;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_fail;
      logic is_free;
      logic hit;
      logic scan_end;
      logic upd_last;
   } status_type;

endpackage

// File: rtl/nfba_ram.sv
module nfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/nfba_ctrl.sv
module nfba_ctrl import nfba_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.req_fail) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.is_free) begin
               cmd.upd_init = 1'b1;
               state_in     = ST_UPDATE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               cmd.upd_init = 1'b1;
               state_in     = ST_UPDATE;
            end else if (status.scan_end) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            cmd.upd_step = 1'b1;
            if (status.upd_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // last map write lands this cycle
            cmd.respond = 1'b1;
            cmd.success = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/nfba_dp.sv
module nfba_dp import nfba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_op,
   input  logic [LEN_W-1:0]   req_length_bytes,
   input  logic [OFF_W-1:0]   req_free_offset,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [OFF_W-1:0]   rsp_region_offset,
   output logic [CNT_W-1:0]   rsp_free_units_left
);

   // request
   logic               op_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [OFF_W-1:0]   off_ff;

   // allocator state
   logic [CNT_W-1:0]   cnt_ff;
   logic [UNIT_W-1:0]  cursor_ff;
   logic [WADDR_W-1:0] clr_ff;

   // scan
   logic [SCAN_W-1:0]  scan_k_ff;
   logic               scan_pend_ff;
   logic [SCAN_W-1:0]  scan_pk_ff;
   logic [RUN_W-1:0]   carry_ff;

   // range update
   logic [UNIT_W-1:0]  start_ff;
   logic [UNIT_W-1:0]  first_ff;
   logic [UNIT_W-1:0]  last_ff;
   logic               set_ff;
   logic [WADDR_W-1:0] upd_w_ff;
   logic               upd_pend_ff;
   logic [WADDR_W-1:0] upd_pa_ff;

   // response
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [OFF_W-1:0]   rsp_offset_ff;
   logic [CNT_W-1:0]   rsp_free_ff;

   // combinational
   logic [LEN_W:0]         len_sum;
   logic [RUN_W-1:0]       need;
   logic [OFF_W-1:0]       free_first_wide;
   logic [UNIT_W-1:0]      free_first;
   logic [RUN_W-1:0]       free_end;
   logic [UNIT_W-1:0]      free_last;
   logic                   is_free;
   logic                   req_fail;

   logic [WADDR_W-1:0]     cur_word;
   logic [WORD_SHIFT-1:0]  cur_bit;
   logic [WADDR_W-1:0]     sc_word;
   logic [WADDR_W-1:0]     sc_rd_addr;
   logic [WORD_BITS-1:0]   rd_data;
   logic [WORD_BITS-1:0]   busy_bits;
   logic [RUN_W-1:0]       carry_in;
   logic [RUN_W-1:0]       carry_out;
   logic [LOCAL_W-1:0]     lastb [WORD_BITS];
   logic [RUN_W-1:0]       total [WORD_BITS];
   logic                   hit_any;
   logic [WORD_SHIFT-1:0]  hit_bit;
   logic [RUN_W-1:0]       hit_start_wide;
   logic [UNIT_W-1:0]      hit_start;

   logic [UNIT_W-1:0]      upd_first;
   logic [UNIT_W-1:0]      upd_last;
   logic [WORD_BITS-1:0]   upd_mask;
   logic [WORD_BITS-1:0]   upd_wdata;

   logic                   ram_wr_en;
   logic [WADDR_W-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic [WADDR_W-1:0]     ram_rd_addr;

   logic [RUN_W-1:0]       cnt_sum;
   logic [CNT_W-1:0]       cnt_next;
   logic [UNIT_W-1:0]      cursor_next;
   logic [OFF_W-1:0]       offset_next;

   // request decode
   always_comb begin
      len_sum         = {1'b0, len_ff} + (LEN_W+1)'(UNIT_BYTES - 1);
      need            = RUN_W'(len_sum >> UNIT_SHIFT);
      free_first_wide = off_ff >> UNIT_SHIFT;
      free_first      = free_first_wide[UNIT_W-1:0];
      free_end        = RUN_W'(free_first) + RUN_W'(need) - RUN_W'(1);
      if (free_end > RUN_W'(MAP_UNITS - 1)) begin
         free_last = UNIT_W'(MAP_UNITS - 1);
      end else begin
         free_last = free_end[UNIT_W-1:0];
      end
      is_free = (op_ff == OP_FREE);
      if (is_free) begin
         req_fail = (32'(free_first_wide) >= MAP_UNITS) || (need == '0);
      end else begin
         req_fail = (len_ff == '0) || (need > RUN_W'(cnt_ff));
      end
   end

   // scan of one map word
   assign cur_word   = cursor_ff[UNIT_W-1:WORD_SHIFT];
   assign cur_bit    = cursor_ff[WORD_SHIFT-1:0];
   assign sc_word    = cur_word + scan_pk_ff[WADDR_W-1:0];
   assign sc_rd_addr = cur_word + scan_k_ff[WADDR_W-1:0];

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         busy_bits[b] = rd_data[b];
         // hold bits before the cursor on entry, and from the cursor on the last word
         if (scan_pk_ff == '0 && WORD_SHIFT'(b) < cur_bit) begin
            busy_bits[b] = 1'b1;
         end
         if (scan_pk_ff == SCAN_W'(MAP_WORDS) && WORD_SHIFT'(b) >= cur_bit) begin
            busy_bits[b] = 1'b1;
         end
      end
      // a run never wraps past the last unit
      carry_in = (sc_word == '0) ? '0 : carry_ff;

      for (int j = 0; j < WORD_BITS; j++) begin
         lastb[j] = '0;
         for (int i = 0; i < WORD_BITS; i++) begin
            if (i <= j && busy_bits[i]) begin
               lastb[j] = LOCAL_W'(i + 1);
            end
         end
         if (lastb[j] == '0) begin
            total[j] = carry_in + RUN_W'(j + 1);
         end else begin
            total[j] = RUN_W'(LOCAL_W'(j + 1) - lastb[j]);
         end
      end

      hit_any = 1'b0;
      hit_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (total[j] >= RUN_W'(need)) begin
            hit_any = 1'b1;
            hit_bit = WORD_SHIFT'(j);
         end
      end

      if (busy_bits == '0) begin
         carry_out = carry_in + RUN_W'(WORD_BITS);
      end else begin
         carry_out = total[WORD_BITS-1];
      end

      hit_start_wide = RUN_W'({sc_word, hit_bit}) + RUN_W'(1) - RUN_W'(need);
      hit_start      = hit_start_wide[UNIT_W-1:0];
   end

   // range to set or clear
   always_comb begin
      if (is_free) begin
         upd_first = free_first;
         upd_last  = free_last;
      end else begin
         upd_first = hit_start;
         upd_last  = hit_start + need[UNIT_W-1:0] - UNIT_W'(1);
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         upd_mask[b] = ({upd_pa_ff, WORD_SHIFT'(b)} >= first_ff) &&
                       ({upd_pa_ff, WORD_SHIFT'(b)} <= last_ff);
      end
      upd_wdata = set_ff ? (rd_data | upd_mask) : (rd_data & ~upd_mask);
   end

   // memory ports
   always_comb begin
      ram_rd_addr = cmd.upd_step ? upd_w_ff : sc_rd_addr;
      ram_wr_en   = cmd.clear_step || upd_pend_ff;
      ram_wr_addr = cmd.clear_step ? clr_ff : upd_pa_ff;
      ram_wr_data = cmd.clear_step ? '0 : upd_wdata;
   end

   nfba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // commit values
   always_comb begin
      cnt_sum     = RUN_W'(cnt_ff) + RUN_W'(need);
      cursor_next = cursor_ff;
      offset_next = '0;
      cnt_next    = cnt_ff;
      if (cmd.success) begin
         if (is_free) begin
            cnt_next = (cnt_sum > RUN_W'(MAP_UNITS)) ? CNT_W'(MAP_UNITS) : cnt_sum[CNT_W-1:0];
         end else begin
            cnt_next    = cnt_ff - need[CNT_W-1:0];
            cursor_next = start_ff + need[UNIT_W-1:0];
            offset_next = OFF_W'(start_ff) << UNIT_SHIFT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CNT_W'(MAP_UNITS);
         cursor_ff    <= '0;
         clr_ff       <= '0;
         scan_pend_ff <= 1'b0;
         upd_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + WADDR_W'(1);
         end
         if (cmd.scan_init) begin
            scan_pend_ff <= 1'b0;
         end else begin
            scan_pend_ff <= cmd.scan_step && (scan_k_ff <= SCAN_W'(MAP_WORDS));
         end
         upd_pend_ff  <= cmd.upd_step;
         rsp_valid_ff <= cmd.respond;
         if (cmd.respond) begin
            cnt_ff    <= cnt_next;
            cursor_ff <= cursor_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         len_ff <= req_length_bytes;
         off_ff <= req_free_offset;
      end
      if (cmd.scan_init) begin
         scan_k_ff <= '0;
         carry_ff  <= '0;
      end else begin
         if (cmd.scan_step && scan_k_ff <= SCAN_W'(MAP_WORDS)) begin
            scan_k_ff  <= scan_k_ff + SCAN_W'(1);
            scan_pk_ff <= scan_k_ff;
         end
         if (scan_pend_ff) begin
            carry_ff <= carry_out;
         end
      end
      if (cmd.upd_init) begin
         first_ff <= upd_first;
         last_ff  <= upd_last;
         upd_w_ff <= upd_first[UNIT_W-1:WORD_SHIFT];
         set_ff   <= !is_free;
         if (!is_free) begin
            start_ff <= hit_start;
         end
      end else if (cmd.upd_step) begin
         upd_w_ff  <= upd_w_ff + WADDR_W'(1);
         upd_pa_ff <= upd_w_ff;
      end
      if (cmd.respond) begin
         rsp_ok_ff     <= cmd.success;
         rsp_offset_ff <= offset_next;
         rsp_free_ff   <= cnt_next;
      end
   end

   always_comb begin
      status.clear_last = (clr_ff == WADDR_W'(MAP_WORDS - 1));
      status.req_fail   = req_fail;
      status.is_free    = is_free;
      status.hit        = scan_pend_ff && hit_any;
      status.scan_end   = scan_pend_ff && (scan_pk_ff == SCAN_W'(MAP_WORDS));
      status.upd_last   = (upd_w_ff == last_ff[UNIT_W-1:WORD_SHIFT]);
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_region_offset   = rsp_offset_ff;
   assign rsp_free_units_left = rsp_free_ff;

endmodule

// File: rtl/next_fit_bitmap_allocator.sv
// Sequence: a request that fails its length or range check is answered from the check state;
// an allocate scans map words from the cursor, 16 map bits per cycle through the map RAM read
// port, then marks the region's words; a free clears its words without a scan.
// Throughput: one request at a time; start is taken only while busy is low.
// Reset: synchronous; a clearing pass zeroes all 64 map words while busy stays high.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
module next_fit_bitmap_allocator import nfba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [LEN_W-1:0]   req_length_bytes,
   input  logic [OFF_W-1:0]   req_free_offset,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [OFF_W-1:0]   rsp_region_offset,
   output logic [CNT_W-1:0]   rsp_free_units_left
);

   cmd_type    cmd;
   status_type status;

   nfba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   nfba_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_op              (req_op),
      .req_length_bytes    (req_length_bytes),
      .req_free_offset     (req_free_offset),
      .rsp_valid           (rsp_valid),
      .rsp_ok              (rsp_ok),
      .rsp_region_offset   (rsp_region_offset),
      .rsp_free_units_left (rsp_free_units_left)
   );

endmodule

// File: rtl/nfba_check.sv
module nfba_check import nfba_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_ok,
   input logic [OFF_W-1:0] rsp_region_offset,
   input logic [CNT_W-1:0] rsp_free_units_left
);

   // an accepted transfer keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after request transfer");

   // results never come in consecutive cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_region_offset == '0))
      else $error("failed request reports an offset");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_units_left <= CNT_W'(MAP_UNITS)))
      else $error("free unit count above map size");

   a_unit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_region_offset % UNIT_BYTES) == '0))
      else $error("region offset not unit aligned");

endmodule

bind next_fit_bitmap_allocator nfba_check u_nfba_check (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_ok              (rsp_ok),
   .rsp_region_offset   (rsp_region_offset),
   .rsp_free_units_left (rsp_free_units_left)
);
